>>> rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/srla_pkg.sv
package srla_pkg;

    localparam int MAX_BINDINGS = 64;
    localparam int MAX_STREAMS  = 64;
    localparam int TIME_BITS    = 16;
    localparam int IDX_W        = (MAX_BINDINGS > 1) ? $clog2(MAX_BINDINGS) : 1;
    localparam int CNT_W        = $clog2(MAX_BINDINGS + 1);
    localparam int FIT_LANES    = 8;

    typedef enum logic [1:0] {
        ST_GRANTED = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOFIT   = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RESERVE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic [5:0]           base;
        logic [6:0]           count;
        logic [1:0]           dir;
        logic [TIME_BITS-1:0] life_begin;
        logic [TIME_BITS-1:0] life_end;
    } t_binding;

    localparam int ENTRY_W = $bits(t_binding);

    // result of one first-fit step over a group of slots
    typedef struct packed {
        logic       found;
        logic [5:0] base;
        logic [6:0] run;
    } t_fit;

    // slots [base, base + count) as a mask
    function automatic logic [MAX_STREAMS-1:0] slot_range(input logic [5:0] base,
                                                          input logic [6:0] count);
        logic [MAX_STREAMS-1:0] r;
        logic [7:0]             lo;
        logic [7:0]             hi;
        lo = {2'b00, base};
        hi = lo + {1'b0, count};
        for (int i = 0; i < MAX_STREAMS; i++) begin
            r[i] = (8'(i) >= lo) && (8'(i) < hi);
        end
        return r;
    endfunction

endpackage

>>> rtl/core/srla_ram.sv
module srla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

>>> rtl/core/srla_fit.sv
module srla_fit
    import srla_pkg::*;
(
    input  logic [MAX_STREAMS-1:0] i_mask,
    input  logic [6:0]             i_pos,
    input  logic [6:0]             i_run,
    input  logic [6:0]             i_count,
    input  logic [6:0]             i_lim,
    output t_fit                   o_fit
);

    // scan FIT_LANES slots from i_pos, tracking the run of free slots
    always_comb begin
        logic [6:0] s;
        logic [6:0] run;
        logic       found;
        logic [5:0] base;
        run   = i_run;
        found = 1'b0;
        base  = '0;
        for (int k = 0; k < FIT_LANES; k++) begin
            s = i_pos + 7'(k);
            if (!found && (s < i_lim)) begin
                if (i_mask[s[5:0]]) begin
                    run = '0;
                end else begin
                    run = run + 7'd1;
                end
                if (run == i_count) begin
                    found = 1'b1;
                    base  = 6'(s - i_count + 7'd1);
                end
            end
        end
        o_fit.found = found;
        o_fit.base  = base;
        o_fit.run   = run;
    end

endmodule

>>> rtl/core/stream_range_lifetime_allocator_top.sv
// First-fit allocator of stream slot ranges over lifetimes. Each accepted request either
// allocates the lowest free base for slot_count slots (operation 0) or claims
// requested_base (operation 1); a range is free when no stored binding of the same
// direction overlaps it in both slots and lifetime [life_begin, life_end). Grants are
// appended to a 64-entry binding table held in a single-port-read RAM. One request is
// in flight at a time: the table is read one entry per cycle to build a mask of occupied
// slots, then the mask is searched eight slots per cycle for operation 0 or checked against
// the requested range for operation 1, and the result is loaded into the output register.
// Invalid requests and requests against a full table skip the scan and the search. A result
// still held by the consumer delays the loading of the next one until it is taken. The next
// request is taken as soon as the result is registered, even if the consumer stalls it. No
// clearing pass is needed after reset: only entries below the binding count are ever read.
`include "assert_macros.svh"

module stream_range_lifetime_allocator_top
    import srla_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [1:0]  i_direction,
    input  logic [5:0]  i_requested_base,
    input  logic [6:0]  i_slot_count,
    input  logic [15:0] i_life_begin,
    input  logic [15:0] i_life_end,
    input  logic [15:0] i_reg_id,
    input  logic        i_reg_id_valid,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [5:0]  o_granted_base,
    output logic [6:0]  o_granted_count,
    output logic [15:0] o_granted_reg_id,
    output logic        o_granted_reg_valid,
    // slots per direction register
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_data
);

    // control state
    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;     // stored bindings
    logic [6:0]            r_spd;                // streams per direction
    logic                  r_out_valid, n_out_valid;

    // request held while it is worked on
    t_op                   r_op, n_op;
    logic [1:0]            r_dir, n_dir;
    logic [5:0]            r_rbase, n_rbase;
    logic [6:0]            r_cnt, n_cnt;
    logic [TIME_BITS-1:0]  r_tbeg, n_tbeg;
    logic [TIME_BITS-1:0]  r_tend, n_tend;
    logic [15:0]           r_rid, n_rid;

    // scan and search state
    logic [CNT_W-1:0]      r_idx, n_idx;         // next table entry to read
    logic                  r_pend, n_pend;       // ram data for last read is valid
    logic [MAX_STREAMS-1:0] r_mask, n_mask;      // occupied slots
    logic [6:0]            r_pos, n_pos;
    logic [6:0]            r_run, n_run;
    logic                  r_found, n_found;
    logic [5:0]            r_base, n_base;
    t_status               r_status, n_status;

    // result register
    t_status               r_o_status, n_o_status;
    logic [5:0]            r_o_base, n_o_base;
    logic [6:0]            r_o_cnt, n_o_cnt;
    logic [15:0]           r_o_rid, n_o_rid;
    logic                  r_o_rvld, n_o_rvld;

    logic [6:0]            lim;
    logic                  in_acc;
    logic                  req_bad;
    logic                  wr_en;
    t_binding              wr_entry;
    t_binding              rd_entry;
    logic [ENTRY_W-1:0]    rd_data;
    t_fit                  fit;

    // register values above the slot count act as the slot count
    assign lim = (r_spd > 7'(MAX_STREAMS)) ? 7'(MAX_STREAMS) : r_spd;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // zero count, empty lifetime, no register id on an allocation, or slots beyond the limit
    always_comb begin
        req_bad = (i_slot_count == '0) ||
                  (i_life_end[TIME_BITS-1:0] <= i_life_begin[TIME_BITS-1:0]);
        if (t_op'(i_operation) == OP_ALLOC) begin
            req_bad = req_bad || !i_reg_id_valid || (i_slot_count > lim);
        end else begin
            req_bad = req_bad ||
                      (({2'b00, i_requested_base} + {1'b0, i_slot_count}) > {1'b0, lim});
        end
    end

    // binding table
    assign wr_entry = '{base: r_base, count: r_cnt, dir: r_dir,
                        life_begin: r_tbeg, life_end: r_tend};
    assign rd_entry = t_binding'(rd_data);

    srla_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_BINDINGS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (wr_entry),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    // one first-fit step over the occupied mask
    srla_fit u_fit (
        .i_mask  (r_mask),
        .i_pos   (r_pos),
        .i_run   (r_run),
        .i_count (r_cnt),
        .i_lim   (lim),
        .o_fit   (fit)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_dir       = r_dir;
        n_rbase     = r_rbase;
        n_cnt       = r_cnt;
        n_tbeg      = r_tbeg;
        n_tend      = r_tend;
        n_rid       = r_rid;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_mask      = r_mask;
        n_pos       = r_pos;
        n_run       = r_run;
        n_found     = r_found;
        n_base      = r_base;
        n_status    = r_status;
        n_o_status  = r_o_status;
        n_o_base    = r_o_base;
        n_o_cnt     = r_o_cnt;
        n_o_rid     = r_o_rid;
        n_o_rvld    = r_o_rvld;
        wr_en       = 1'b0;

        // consumer took the result
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op    = t_op'(i_operation);
                    n_dir   = i_direction;
                    n_rbase = i_requested_base;
                    n_cnt   = i_slot_count;
                    n_tbeg  = i_life_begin[TIME_BITS-1:0];
                    n_tend  = i_life_end[TIME_BITS-1:0];
                    n_rid   = i_reg_id;
                    n_idx   = '0;
                    n_mask  = '0;
                    n_pos   = '0;
                    n_run   = '0;
                    n_found = 1'b0;
                    n_base  = '0;
                    // validity first, then a full table, then the search
                    if (req_bad) begin
                        n_status = ST_INVALID;
                        n_state  = S_RESULT;
                    end else if (r_count >= CNT_W'(MAX_BINDINGS)) begin
                        n_status = ST_FULL;
                        n_state  = S_RESULT;
                    end else begin
                        n_status = ST_NOFIT;
                        n_state  = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // merge the entry read last cycle if it shares direction and lifetime
                if (r_pend && (rd_entry.dir == r_dir) &&
                    (r_tbeg < rd_entry.life_end) && (r_tend > rd_entry.life_begin)) begin
                    n_mask = r_mask | slot_range(rd_entry.base, rd_entry.count);
                end
                if (r_idx < r_count) begin
                    n_idx  = r_idx + CNT_W'(1);
                    n_pend = 1'b1;
                end else begin
                    n_state = S_FIT;
                end
            end

            S_FIT: begin
                if (r_op == OP_RESERVE) begin
                    n_found = ~|(r_mask & slot_range(r_rbase, r_cnt));
                    n_base  = r_rbase;
                    n_state = S_RESULT;
                end else begin
                    n_run = fit.run;
                    n_pos = r_pos + 7'(FIT_LANES);
                    if (fit.found) begin
                        n_found = 1'b1;
                        n_base  = fit.base;
                        n_state = S_RESULT;
                    end else if (({1'b0, r_pos} + 8'(FIT_LANES)) >= {1'b0, lim}) begin
                        n_state = S_RESULT;
                    end
                end
            end

            S_RESULT: begin
                // load the result register once it is free, record the grant
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    n_o_status  = r_found ? ST_GRANTED : r_status;
                    n_o_base    = r_found ? r_base : '0;
                    n_o_cnt     = r_found ? r_cnt : '0;
                    n_o_rid     = (r_found && (r_op == OP_ALLOC)) ? r_rid : '0;
                    n_o_rvld    = r_found && (r_op == OP_ALLOC);
                    if (r_found) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_spd       <= 7'(MAX_STREAMS);
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            if (i_cfg_we) begin
                r_spd <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_dir      <= n_dir;
        r_rbase    <= n_rbase;
        r_cnt      <= n_cnt;
        r_tbeg     <= n_tbeg;
        r_tend     <= n_tend;
        r_rid      <= n_rid;
        r_idx      <= n_idx;
        r_mask     <= n_mask;
        r_pos      <= n_pos;
        r_run      <= n_run;
        r_found    <= n_found;
        r_base     <= n_base;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_base   <= n_o_base;
        r_o_cnt    <= n_o_cnt;
        r_o_rid    <= n_o_rid;
        r_o_rvld   <= n_o_rvld;
    end

    assign o_out_valid         = r_out_valid;
    assign o_status            = r_o_status;
    assign o_granted_base      = r_o_base;
    assign o_granted_count     = r_o_cnt;
    assign o_granted_reg_id    = r_o_rid;
    assign o_granted_reg_valid = r_o_rvld;

    // a grant is only written into a table with room left
    `ASSERT_IMP(a_write_room, i_clk, i_rst_n, wr_en, r_count < CNT_W'(MAX_BINDINGS))
    // every table write bumps the binding count by one
    `ASSERT_NXT(a_write_count, i_clk, i_rst_n, wr_en, r_count == $past(r_count) + CNT_W'(1))
    // an accepted request always leaves idle
    `ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_acc, r_state != S_IDLE)
    // a granted result never carries an empty range
    `ASSERT_IMP(a_grant_count, i_clk, i_rst_n, o_out_valid && (o_status == ST_GRANTED),
                o_granted_count != 7'd0)

endmodule
